// ===== rtl/lgf_pkg.sv =====
// Shared types and codes for the lifecycle gate state machine.
package lgf_pkg;

    // Parameter defaults
    localparam int DEPTH_BITS_DEF = 16;
    localparam int GEN_BITS_DEF   = 64;

    // Lifecycle states
    typedef enum logic [3:0] {
        ST_BOOT     = 4'd0,
        ST_ACTIVE   = 4'd1,
        ST_QUIESCE  = 4'd2,
        ST_BASELINE = 4'd3,
        ST_SAVING   = 4'd4,
        ST_REAPPLY  = 4'd5,
        ST_SHUTDOWN = 4'd6,
        ST_STOPPED  = 4'd7,
        ST_FAILED   = 4'd8
    } life_state_t;

    // Event codes on the request word
    localparam logic [3:0] EV_ACTIVATE      = 4'd0;
    localparam logic [3:0] EV_SAVE_BEGIN    = 4'd1;
    localparam logic [3:0] EV_SAVE_OK       = 4'd2;
    localparam logic [3:0] EV_SAVE_FAIL     = 4'd3;
    localparam logic [3:0] EV_SAVE_CANCEL   = 4'd4;
    localparam logic [3:0] EV_REAPPLY       = 4'd5;
    localparam logic [3:0] EV_SHUTDOWN_REQ  = 4'd6;
    localparam logic [3:0] EV_SHUTDOWN_DONE = 4'd7;
    localparam logic [3:0] EV_INTERRUPT     = 4'd8;

    // Diagnostic codes
    typedef enum logic [1:0] {
        DIAG_NONE    = 2'd0,
        DIAG_INVALID = 2'd1,
        DIAG_NOACK   = 2'd2
    } diag_t;

    // Verdict flags from the transition logic
    typedef struct packed {
        logic  rejected;
        diag_t diag;
        logic  mutation_ok;
    } step_flags_t;

endpackage

// ===== rtl/lgf_step.sv =====
// Transition logic: one event against the current lifecycle state.
module lgf_step #(
    parameter int DEPTH_BITS = lgf_pkg::DEPTH_BITS_DEF,
    parameter int GEN_BITS   = lgf_pkg::GEN_BITS_DEF
) (
    input  logic [3:0]              req_type,
    input  logic                    baseline_ack,
    input  lgf_pkg::life_state_t    cur_state,
    input  logic [DEPTH_BITS-1:0]   cur_nesting,
    input  logic [GEN_BITS-1:0]     cur_gen,
    output lgf_pkg::life_state_t    next_state,
    output logic [DEPTH_BITS-1:0]   next_nesting,
    output logic [GEN_BITS-1:0]     next_gen,
    output lgf_pkg::step_flags_t    flags
);

    localparam logic [DEPTH_BITS-1:0] NEST_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] NEST_ONE = DEPTH_BITS'(1);

    lgf_pkg::diag_t diag;
    logic           can_exit;

    // States from which shutdown or interrupt may leave, ack aside
    assign can_exit = (cur_state == lgf_pkg::ST_BOOT)     ||
                      (cur_state == lgf_pkg::ST_ACTIVE)   ||
                      (cur_state == lgf_pkg::ST_QUIESCE)  ||
                      (cur_state == lgf_pkg::ST_BASELINE) ||
                      (cur_state == lgf_pkg::ST_SAVING)   ||
                      (cur_state == lgf_pkg::ST_REAPPLY);

    // Next state, nesting depth, generation and diagnostic
    always_comb begin
        next_state   = cur_state;
        next_nesting = cur_nesting;
        next_gen     = cur_gen;
        diag         = lgf_pkg::DIAG_NONE;
        case (req_type)
            lgf_pkg::EV_ACTIVATE: begin
                if (cur_state != lgf_pkg::ST_BOOT) begin
                    diag = lgf_pkg::DIAG_INVALID;
                end else begin
                    next_state = lgf_pkg::ST_ACTIVE;
                    next_gen   = cur_gen + GEN_BITS'(1);
                end
            end
            lgf_pkg::EV_SAVE_BEGIN: begin
                if (cur_state == lgf_pkg::ST_SAVING) begin
                    // nest deeper, saturating
                    if (cur_nesting != NEST_MAX) begin
                        next_nesting = cur_nesting + NEST_ONE;
                    end
                end else if (cur_state != lgf_pkg::ST_ACTIVE) begin
                    diag = lgf_pkg::DIAG_INVALID;
                end else if (!baseline_ack) begin
                    diag = lgf_pkg::DIAG_NOACK;
                end else begin
                    next_state   = lgf_pkg::ST_SAVING;
                    next_nesting = NEST_ONE;
                end
            end
            lgf_pkg::EV_SAVE_OK, lgf_pkg::EV_SAVE_FAIL, lgf_pkg::EV_SAVE_CANCEL: begin
                if (cur_state != lgf_pkg::ST_SAVING) begin
                    diag = lgf_pkg::DIAG_INVALID;
                end else if (cur_nesting <= NEST_ONE) begin
                    // outermost save closes: a zero depth counts as one
                    next_nesting = '0;
                    next_state   = lgf_pkg::ST_REAPPLY;
                end else begin
                    next_nesting = cur_nesting - NEST_ONE;
                end
            end
            lgf_pkg::EV_REAPPLY: begin
                if (cur_state != lgf_pkg::ST_REAPPLY) begin
                    diag = lgf_pkg::DIAG_INVALID;
                end else begin
                    next_state = lgf_pkg::ST_ACTIVE;
                    next_gen   = cur_gen + GEN_BITS'(1);
                end
            end
            lgf_pkg::EV_SHUTDOWN_REQ, lgf_pkg::EV_INTERRUPT: begin
                if (!can_exit) begin
                    diag = lgf_pkg::DIAG_INVALID;
                end else if (cur_state == lgf_pkg::ST_ACTIVE && !baseline_ack) begin
                    diag = lgf_pkg::DIAG_NOACK;
                end else begin
                    next_nesting = '0;
                    next_state   = (req_type == lgf_pkg::EV_INTERRUPT) ?
                                   lgf_pkg::ST_FAILED : lgf_pkg::ST_SHUTDOWN;
                end
            end
            lgf_pkg::EV_SHUTDOWN_DONE: begin
                if (cur_state != lgf_pkg::ST_SHUTDOWN) begin
                    diag = lgf_pkg::DIAG_INVALID;
                end else begin
                    next_state = lgf_pkg::ST_STOPPED;
                end
            end
            default: begin
                diag = lgf_pkg::DIAG_INVALID;
            end
        endcase
    end

    // Result flags from the verdict and the state reached
    always_comb begin
        flags.rejected    = (diag != lgf_pkg::DIAG_NONE);
        flags.diag        = diag;
        flags.mutation_ok = (next_state == lgf_pkg::ST_ACTIVE);
    end

endmodule

// ===== rtl/lifecycle_gate_fsm_top.sv =====
// Top level of the lifecycle gate state machine.
//
// Usage:
//   The s_ channel carries one lifecycle event per word (s_req_type and
//   s_baseline_ack); the m_ channel returns exactly one result word per event:
//   applied/rejected status, diagnostic, prior and new state, the activation
//   generation after the event and the mutation-permitted flag.
//   Both channels use valid/ready; a word moves when both are high.
//   A word accepted into the input register passes through the transition
//   logic into the result register, which drives the m_ ports.
//   Throughput: one event per cycle, sustained; the state update for an
//   event is a single pass of transition logic between the input register
//   and the result register, and the state registers load together with
//   the result register, so the next event sees the updated state.
//   Stalls: while m_ready is low the result holds; the input register still
//   takes one more word, after which s_ready drops until the result drains.
//   Reset (aresetn low, synchronous): state goes to bootstrap, save depth
//   and generation counter to zero, both pipeline stages empty.
module lifecycle_gate_fsm_top #(
    parameter int DEPTH_BITS = lgf_pkg::DEPTH_BITS_DEF,
    parameter int GEN_BITS   = lgf_pkg::GEN_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_req_type,
    input  logic                s_baseline_ack,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_status,
    output logic [1:0]          m_diagnostic,
    output logic [3:0]          m_prior_state,
    output logic [3:0]          m_new_state,
    output logic [GEN_BITS-1:0] m_gen_count,
    output logic                m_mutation_ok
);

    // Input stage
    logic                 in_valid_reg;
    logic [3:0]           in_req_reg;
    logic                 in_ack_reg;

    // Architectural state
    lgf_pkg::life_state_t  state_reg;
    lgf_pkg::life_state_t  state_next;
    logic [DEPTH_BITS-1:0] nesting_reg;
    logic [DEPTH_BITS-1:0] nesting_next;
    logic [GEN_BITS-1:0]   gen_reg;
    logic [GEN_BITS-1:0]   gen_next;
    lgf_pkg::step_flags_t  flags_next;

    // Result stage
    logic                 out_valid_reg;
    lgf_pkg::step_flags_t out_flags_reg;
    lgf_pkg::life_state_t out_prior_reg;
    lgf_pkg::life_state_t out_new_reg;
    logic [GEN_BITS-1:0]  out_gen_reg;

    logic out_load;
    logic in_load;

    // Handshake: advance when the result slot is free or draining
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    lgf_step #(
        .DEPTH_BITS (DEPTH_BITS),
        .GEN_BITS   (GEN_BITS)
    ) u_step (
        .req_type     (in_req_reg),
        .baseline_ack (in_ack_reg),
        .cur_state    (state_reg),
        .cur_nesting  (nesting_reg),
        .cur_gen      (gen_reg),
        .next_state   (state_next),
        .next_nesting (nesting_next),
        .next_gen     (gen_next),
        .flags        (flags_next)
    );

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (out_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_req_reg <= s_req_type;
            in_ack_reg <= s_baseline_ack;
        end
    end

    // Commit the state together with the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lgf_pkg::ST_BOOT;
            nesting_reg <= '0;
            gen_reg     <= '0;
        end else if (out_load) begin
            state_reg   <= state_next;
            nesting_reg <= nesting_next;
            gen_reg     <= gen_next;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_flags_reg <= flags_next;
            out_prior_reg <= state_reg;
            out_new_reg   <= state_next;
            out_gen_reg   <= gen_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_flags_reg.rejected;
    assign m_diagnostic  = out_flags_reg.diag;
    assign m_prior_state = out_prior_reg;
    assign m_new_state   = out_new_reg;
    assign m_gen_count   = out_gen_reg;
    assign m_mutation_ok = out_flags_reg.mutation_ok;

    // Transient states never appear as a result state
    a_no_transient: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_new_state != lgf_pkg::ST_QUIESCE &&
                     m_new_state != lgf_pkg::ST_BASELINE))
        else $error("transient state reported as new state");

    // A rejected event leaves the state where it was
    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_new_state == m_prior_state &&
                                   m_diagnostic != lgf_pkg::DIAG_NONE))
        else $error("rejected event changed state");

    // The shown result matches the committed state
    a_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_new_state == state_reg && m_gen_count == gen_reg &&
                     m_mutation_ok == (state_reg == lgf_pkg::ST_ACTIVE)))
        else $error("result disagrees with committed state");

    // The generation only moves on an entry into Active
    a_gen_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && gen_next != gen_reg) |->
            (state_next == lgf_pkg::ST_ACTIVE && state_reg != lgf_pkg::ST_ACTIVE))
        else $error("generation moved without entering Active");

endmodule

// ===== verif/tb_lifecycle_gate_fsm_top.sv =====
// Self-checking testbench for the lifecycle gate state machine top level.
`timescale 1ns / 100ps

module tb_lifecycle_gate_fsm_top;

    localparam int DEPTH_BITS = 16;
    localparam int GEN_BITS   = 64;

    // Codes outside the event set
    localparam logic [3:0] EV_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] EV_UNKNOWN_HI = 4'd15;

    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int NEST_LEVELS      = 7;

    // One expected result word
    typedef struct {
        logic                 rejected;
        lgf_pkg::diag_t       diag;
        lgf_pkg::life_state_t prior;
        lgf_pkg::life_state_t after;
        logic [GEN_BITS-1:0]  gen;
        logic                 mutation_ok;
    } lifecycle_result_t;

    // Tracks the lifecycle state and holds the result words still owed by the block
    class lifecycle_tracker;
        lgf_pkg::life_state_t  cur_state  = lgf_pkg::ST_BOOT;
        logic [DEPTH_BITS-1:0] save_depth = '0;
        logic [GEN_BITS-1:0]   act_gen    = '0;
        lifecycle_result_t     awaited[$];
        int                    errors     = 0;

        // Leave toward shutdown or failed; return the diagnostic
        function lgf_pkg::diag_t leave_to(logic ack, lgf_pkg::life_state_t target);
            if (cur_state == lgf_pkg::ST_ACTIVE) begin
                if (!ack) return lgf_pkg::DIAG_NOACK;
            end else if (!(cur_state inside {lgf_pkg::ST_BOOT, lgf_pkg::ST_QUIESCE,
                                             lgf_pkg::ST_BASELINE, lgf_pkg::ST_SAVING,
                                             lgf_pkg::ST_REAPPLY})) begin
                return lgf_pkg::DIAG_INVALID;
            end
            save_depth = '0;
            cur_state  = target;
            return lgf_pkg::DIAG_NONE;
        endfunction

        // Apply one accepted event word and queue the result it owes
        function void note_event(logic [3:0] req, logic ack);
            lifecycle_result_t r;
            lgf_pkg::diag_t    d;
            r.prior = cur_state;
            d = lgf_pkg::DIAG_NONE;
            case (req)
                lgf_pkg::EV_ACTIVATE: begin
                    if (cur_state != lgf_pkg::ST_BOOT) begin
                        d = lgf_pkg::DIAG_INVALID;
                    end else begin
                        cur_state = lgf_pkg::ST_ACTIVE;
                        act_gen   = act_gen + 1'b1;
                    end
                end
                lgf_pkg::EV_SAVE_BEGIN: begin
                    if (cur_state == lgf_pkg::ST_SAVING) begin
                        if (save_depth != {DEPTH_BITS{1'b1}}) save_depth = save_depth + 1'b1;
                    end else if (cur_state != lgf_pkg::ST_ACTIVE) begin
                        d = lgf_pkg::DIAG_INVALID;
                    end else if (!ack) begin
                        d = lgf_pkg::DIAG_NOACK;
                    end else begin
                        cur_state  = lgf_pkg::ST_SAVING;
                        save_depth = DEPTH_BITS'(1);
                    end
                end
                lgf_pkg::EV_SAVE_OK, lgf_pkg::EV_SAVE_FAIL, lgf_pkg::EV_SAVE_CANCEL: begin
                    if (cur_state != lgf_pkg::ST_SAVING) begin
                        d = lgf_pkg::DIAG_INVALID;
                    end else if (save_depth <= DEPTH_BITS'(1)) begin
                        save_depth = '0;
                        cur_state  = lgf_pkg::ST_REAPPLY;
                    end else begin
                        save_depth = save_depth - 1'b1;
                    end
                end
                lgf_pkg::EV_REAPPLY: begin
                    if (cur_state != lgf_pkg::ST_REAPPLY) begin
                        d = lgf_pkg::DIAG_INVALID;
                    end else begin
                        cur_state = lgf_pkg::ST_ACTIVE;
                        act_gen   = act_gen + 1'b1;
                    end
                end
                lgf_pkg::EV_SHUTDOWN_REQ: d = leave_to(ack, lgf_pkg::ST_SHUTDOWN);
                lgf_pkg::EV_SHUTDOWN_DONE: begin
                    if (cur_state != lgf_pkg::ST_SHUTDOWN) d = lgf_pkg::DIAG_INVALID;
                    else cur_state = lgf_pkg::ST_STOPPED;
                end
                lgf_pkg::EV_INTERRUPT: d = leave_to(ack, lgf_pkg::ST_FAILED);
                default: d = lgf_pkg::DIAG_INVALID;
            endcase
            r.rejected    = (d != lgf_pkg::DIAG_NONE);
            r.diag        = d;
            r.after       = cur_state;
            r.gen         = act_gen;
            r.mutation_ok = (cur_state == lgf_pkg::ST_ACTIVE);
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_result(logic st, logic [1:0] dg, logic [3:0] ps, logic [3:0] ns,
                                   logic [GEN_BITS-1:0] gc, logic mo);
            lifecycle_result_t r;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing awaited, expected none, actual %0h",
                         $time, {st, dg, ps, ns});
                return;
            end
            r = awaited.pop_front();
            compare_field("status",      64'(r.rejected),    64'(st));
            compare_field("diagnostic",  64'(r.diag),        64'(dg));
            compare_field("prior_state", 64'(r.prior),       64'(ps));
            compare_field("new_state",   64'(r.after),       64'(ns));
            compare_field("gen_count",   64'(r.gen),         64'(gc));
            compare_field("mutation_ok", 64'(r.mutation_ok), 64'(mo));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [3:0]          s_req_type     = '0;
    logic                s_baseline_ack = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_status;
    logic [1:0]          m_diagnostic;
    logic [3:0]          m_prior_state;
    logic [3:0]          m_new_state;
    logic [GEN_BITS-1:0] m_gen_count;
    logic                m_mutation_ok;

    logic send_idle = 1'b1;
    logic recv_idle = 1'b1;
    int   hold_reqs = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    lifecycle_tracker sb = new();

    lifecycle_gate_fsm_top #(
        .DEPTH_BITS (DEPTH_BITS),
        .GEN_BITS   (GEN_BITS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_baseline_ack (s_baseline_ack),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_diagnostic   (m_diagnostic),
        .m_prior_state  (m_prior_state),
        .m_new_state    (m_new_state),
        .m_gen_count    (m_gen_count),
        .m_mutation_ok  (m_mutation_ok)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Offer one event word, optionally after an idle burst, and hold it until taken
    task automatic offer_event(input logic [3:0] req, input logic ack);
        if (send_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_baseline_ack <= ack;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_event(req, ack);
    endtask

    // Stop offering until every owed result word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    // Pick an event that keeps the lifecycle cycling, with some noise
    function automatic void choose_event(output logic [3:0] req, output logic ack);
        int r;
        r   = $urandom_range(0, 9);
        ack = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            // noise: never let it reach a terminal state
            req = 4'($urandom_range(0, 15));
            if (req == lgf_pkg::EV_SHUTDOWN_REQ || req == lgf_pkg::EV_INTERRUPT) begin
                if (sb.cur_state == lgf_pkg::ST_ACTIVE) ack = 1'b0;
                else req = 4'($urandom_range(EV_UNKNOWN_LO, EV_UNKNOWN_HI));
            end
            return;
        end
        case (sb.cur_state)
            lgf_pkg::ST_ACTIVE: begin
                if (r <= 6) begin
                    req = lgf_pkg::EV_SAVE_BEGIN;
                    ack = ($urandom_range(0, 4) != 0);
                end else if (r == 7) begin
                    req = lgf_pkg::EV_SHUTDOWN_REQ;
                    ack = 1'b0;
                end else if (r == 8) begin
                    req = lgf_pkg::EV_INTERRUPT;
                    ack = 1'b0;
                end else begin
                    req = lgf_pkg::EV_REAPPLY;
                end
            end
            lgf_pkg::ST_SAVING: begin
                if (r <= 3) req = lgf_pkg::EV_SAVE_BEGIN;
                else req = lgf_pkg::EV_SAVE_OK + 4'($urandom_range(0, 2));
            end
            lgf_pkg::ST_REAPPLY: begin
                if (r <= 7) req = lgf_pkg::EV_REAPPLY;
                else req = lgf_pkg::EV_SAVE_OK + 4'($urandom_range(0, 2));
            end
            default: req = 4'($urandom_range(EV_UNKNOWN_LO, EV_UNKNOWN_HI));
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [3:0] req;
        logic       ack;
        repeat (count) begin
            choose_event(req, ack);
            offer_event(req, ack);
        end
    endtask

    // Take result words and drive m_ready with bursts and long holds
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_status, m_diagnostic, m_prior_state, m_new_state,
                                m_gen_count, m_mutation_ok);
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0) m_ready <= 1'b1;
            end else if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = LONG_HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 7);
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Main stimulus
    initial begin
        logic [3:0] req;
        logic       ack;
        int         waited;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Rejections from bootstrap
        offer_event(EV_UNKNOWN_HI,                1'b1);
        offer_event(lgf_pkg::EV_SAVE_BEGIN,       1'b1);
        offer_event(lgf_pkg::EV_SAVE_OK,          1'b1);
        offer_event(lgf_pkg::EV_REAPPLY,          1'b0);
        offer_event(lgf_pkg::EV_SHUTDOWN_DONE,    1'b1);
        // Activate, then events that need the acknowledge or are invalid in active
        offer_event(lgf_pkg::EV_ACTIVATE,         1'b0);
        offer_event(lgf_pkg::EV_ACTIVATE,         1'b1);
        offer_event(lgf_pkg::EV_SAVE_BEGIN,       1'b0);
        offer_event(lgf_pkg::EV_SHUTDOWN_REQ,     1'b0);
        offer_event(lgf_pkg::EV_INTERRUPT,        1'b0);
        offer_event(EV_UNKNOWN_LO,                1'b0);
        offer_event(lgf_pkg::EV_SHUTDOWN_DONE,    1'b0);
        // Nested save without acknowledge, each save end, reapply
        offer_event(lgf_pkg::EV_SAVE_BEGIN,       1'b1);
        offer_event(lgf_pkg::EV_SAVE_BEGIN,       1'b0);
        offer_event(lgf_pkg::EV_ACTIVATE,         1'b1);
        offer_event(lgf_pkg::EV_SAVE_FAIL,        1'b0);
        offer_event(lgf_pkg::EV_SAVE_CANCEL,      1'b1);
        offer_event(lgf_pkg::EV_SAVE_OK,          1'b1);
        offer_event(lgf_pkg::EV_SAVE_BEGIN,       1'b1);
        offer_event(lgf_pkg::EV_REAPPLY,          1'b1);
        offer_event(lgf_pkg::EV_SAVE_BEGIN,       1'b1);
        offer_event(lgf_pkg::EV_SAVE_OK,          1'b0);
        offer_event(lgf_pkg::EV_REAPPLY,          1'b0);

        // Nest the save depth several levels and unwind it completely
        send_idle = 1'b0;
        offer_event(lgf_pkg::EV_SAVE_BEGIN, 1'b1);
        repeat (NEST_LEVELS - 1)
            offer_event(lgf_pkg::EV_SAVE_BEGIN, 1'($urandom_range(0, 1)));
        repeat (NEST_LEVELS)
            offer_event(lgf_pkg::EV_SAVE_OK + 4'($urandom_range(0, 2)),
                        1'($urandom_range(0, 1)));
        offer_event(lgf_pkg::EV_REAPPLY, 1'b1);
        send_idle = 1'b1;

        run_random(400);

        // Hold the receiver off while words keep coming
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_reqs++;
        run_random(100);
        send_idle = 1'b1;
        recv_idle = 1'b1;

        drain_results();
        run_random(500);

        // Stretch with no idling on either side
        send_idle = 1'b0;
        recv_idle = 1'b0;
        run_random(300);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        run_random(200);

        // Final part: leave toward a terminal state, then probe it
        send_idle = 1'b0;
        recv_idle = 1'b0;
        ack = (sb.cur_state == lgf_pkg::ST_ACTIVE) ? 1'b1 : 1'($urandom_range(0, 1));
        offer_event($urandom_range(0, 1) ? lgf_pkg::EV_SHUTDOWN_REQ : lgf_pkg::EV_INTERRUPT,
                    ack);
        if (sb.cur_state == lgf_pkg::ST_SHUTDOWN && $urandom_range(0, 1))
            offer_event(lgf_pkg::EV_SHUTDOWN_DONE, 1'($urandom_range(0, 1)));
        repeat (40) begin
            req = 4'($urandom_range(0, 15));
            offer_event(req, 1'($urandom_range(0, 1)));
        end

        // Wait out the owed results, then watch for stray ones
        s_valid <= 1'b0;
        waited = 0;
        while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);

        if (sb.outstanding() != 0)
            $display("%0t: %0d result words never arrived", $time, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd12 * 64'd6_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lgf_pkg.sv
rtl/lgf_step.sv
rtl/lifecycle_gate_fsm_top.sv
verif/tb_lifecycle_gate_fsm_top.sv
